### src/per_shard_row_block_assigner_assert.svh
// Assertion macros for the row block assigner.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef PER_SHARD_ROW_BLOCK_ASSIGNER_ASSERT_SVH
`define PER_SHARD_ROW_BLOCK_ASSIGNER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define PSRBA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define PSRBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PSRBA_ASSERT_IMPL(label, ante, cons, msg)
`define PSRBA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/psrba_pkg.sv
package psrba_pkg;

	// Fixed field widths
	localparam int SHARD_W    = 4;
	localparam int ROW_SIZE_W = 24;
	localparam int ROW_W      = 20;
	localparam int BYTE_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT = 2'd1;

	// Register reset values
	localparam logic [ROW_W-1:0]  ROW_LIMIT_RST  = 20'd65536;
	localparam logic [BYTE_W-1:0] BYTE_LIMIT_RST = 32'd268435456;

	// Request to the block id allocator
	typedef struct packed {
		logic fire;   // commit this cycle's result
		logic clear;  // batch restart: count from zero
		logic take;   // a new block id is needed
	} alloc_req_t;

endpackage

### src/per_shard_row_block_assigner.sv
// The meter word is read at the edge that accepts the input word into stage 1; the update, the
// write back and the result word follow when stage 1 fires, which waits while the output word is not taken.
// Throughput: one row per cycle while out_ready holds; a forwarding register covers back-to-back
// rows of one shard, set by the single read port and single write port of the meter memory.
// Reset: open flags and the block counter clear, limits return to 65536 rows and 268435456
// bytes; meter memory contents are not cleared and are read only behind an open flag.
`include "per_shard_row_block_assigner_assert.svh"

module per_shard_row_block_assigner #(
	parameter int SHARDS        = 16,
	parameter int BLOCK_ID_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 first_row,
	input  logic [psrba_pkg::SHARD_W-1:0]        shard,
	input  logic [psrba_pkg::ROW_SIZE_W-1:0]     row_size,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [BLOCK_ID_BITS-1:0]             block_id,
	output logic                                 opened_block,
	output logic                                 overflow,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [psrba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psrba_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int SIDX_W = (SHARDS > 1) ? $clog2(SHARDS) : 1;
	localparam int ROW_W  = psrba_pkg::ROW_W;
	localparam int BYTE_W = psrba_pkg::BYTE_W;
	localparam int RB_W   = psrba_pkg::ROW_SIZE_W;
	localparam int MW     = ROW_W + BYTE_W + BLOCK_ID_BITS;

	// Configuration
	logic [ROW_W-1:0]  row_limit_q;
	logic [BYTE_W-1:0] byte_limit_q;

	// Stage 1: row waiting for its meter word
	logic              s1_valid_q;
	logic              first_s1;
	logic [SIDX_W-1:0] idx_s1;
	logic [RB_W-1:0]   bytes_s1;

	// Meter state
	logic [SHARDS-1:0] valid_q;
	logic [SHARDS-1:0] nxt_valid;
	logic              fwd_valid_q;
	logic [SIDX_W-1:0] fwd_idx_q;
	logic [MW-1:0]     fwd_data_q;

	// Output register
	logic                     out_valid_q;
	logic [BLOCK_ID_BITS-1:0] blk_id_q;
	logic                     opened_q;
	logic                     ovf_out_q;

	logic [SIDX_W-1:0]        shard_idx;
	logic                     in_fire;
	logic                     s1_fire;
	logic [MW-1:0]            rd_data;
	logic [MW-1:0]            cur_word;
	logic                     fwd_hit;
	logic                     cur_open;
	logic [ROW_W-1:0]         cur_rows;
	logic [BYTE_W-1:0]        cur_bytes;
	logic [BLOCK_ID_BITS-1:0] cur_blk;
	logic [BYTE_W:0]          byte_sum;
	logic                     keep;
	logic [ROW_W-1:0]         new_rows;
	logic [BYTE_W-1:0]        new_bytes;
	logic [BLOCK_ID_BITS-1:0] new_blk;
	logic [MW-1:0]            new_word;
	logic [BLOCK_ID_BITS-1:0] alloc_id;
	logic                     alloc_ovf;
	psrba_pkg::alloc_req_t    alloc_req;

	// Fold the shard field onto the shards present
	always_comb begin
		shard_idx = '0;
		for (int i = 0; i < (1 << psrba_pkg::SHARD_W); i++) begin
			if (shard == psrba_pkg::SHARD_W'(i)) begin
				shard_idx = SIDX_W'(i % SHARDS);
			end
		end
	end

	// Handshakes
	assign s1_fire   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || s1_fire;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Write limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_limit_q  <= psrba_pkg::ROW_LIMIT_RST;
			byte_limit_q <= psrba_pkg::BYTE_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psrba_pkg::REG_ROW_LIMIT: begin
					row_limit_q <= cfg_data[ROW_W-1:0];
				end
				psrba_pkg::REG_BYTE_LIMIT: begin
					byte_limit_q <= cfg_data[BYTE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			first_s1 <= first_row;
			idx_s1   <= shard_idx;
			bytes_s1 <= row_size;
		end
	end

	psrba_meter_ram #(
		.DEPTH (SHARDS),
		.AW    (SIDX_W),
		.DW    (MW)
	) u_meter_ram (
		.clk     (clk),
		.wr_en   (s1_fire),
		.wr_addr (idx_s1),
		.wr_data (new_word),
		.rd_en   (in_fire),
		.rd_addr (shard_idx),
		.rd_data (rd_data)
	);

	// Take the latest write when it hit the same shard
	assign fwd_hit  = fwd_valid_q && (fwd_idx_q == idx_s1);
	assign cur_word = fwd_hit ? fwd_data_q : rd_data;
	assign cur_rows  = cur_word[MW-1 -: ROW_W];
	assign cur_bytes = cur_word[BLOCK_ID_BITS +: BYTE_W];
	assign cur_blk   = cur_word[BLOCK_ID_BITS-1:0];
	assign cur_open  = !first_s1 && valid_q[idx_s1];

	// Decide whether the row fits the shard's current block
	assign byte_sum = {1'b0, cur_bytes} + {{(BYTE_W + 1 - RB_W){1'b0}}, bytes_s1};
	assign keep = cur_open && (cur_rows < row_limit_q) && (byte_sum <= {1'b0, byte_limit_q});

	assign alloc_req.fire  = s1_fire;
	assign alloc_req.clear = first_s1;
	assign alloc_req.take  = !keep;

	psrba_alloc #(
		.BLOCK_ID_BITS (BLOCK_ID_BITS)
	) u_alloc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alloc_req),
		.id     (alloc_id),
		.ovf    (alloc_ovf)
	);

	// Count the row into its block
	assign new_rows  = keep ? cur_rows + ROW_W'(1) : ROW_W'(1);
	assign new_bytes = keep ? byte_sum[BYTE_W-1:0] : {{(BYTE_W - RB_W){1'b0}}, bytes_s1};
	assign new_blk   = keep ? cur_blk : alloc_id;
	assign new_word  = {new_rows, new_bytes, new_blk};

	// Open flags: drop all on a batch restart, then mark this shard
	always_comb begin
		nxt_valid = first_s1 ? '0 : valid_q;
		nxt_valid[idx_s1] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fwd_valid_q <= 1'b0;
		end else if (s1_fire) begin
			valid_q     <= nxt_valid;
			fwd_valid_q <= 1'b1;
		end
	end

	// Hold the last written meter word for the next row
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= new_word;
		end
	end

	// Output word control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			blk_id_q  <= new_blk;
			opened_q  <= !keep;
			ovf_out_q <= alloc_ovf;
		end
	end

	assign out_valid    = out_valid_q;
	assign block_id     = blk_id_q;
	assign opened_block = opened_q;
	assign overflow     = ovf_out_q;

	`PSRBA_ASSERT_NEXT(a_restart_one_open, s1_fire && first_s1, $onehot(valid_q), "restart left other shards open")
	`PSRBA_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_fire, s1_valid_q && $stable(idx_s1), "stalled row lost")
	`PSRBA_ASSERT_NEXT(a_result_follows, s1_fire, out_valid_q && (opened_q == $past(!keep)), "result word missing")
	`PSRBA_ASSERT_IMPL(a_kept_needs_open, s1_fire && keep, valid_q[idx_s1] && !first_s1, "row kept in closed block")

endmodule

### src/psrba_meter_ram.sv
module psrba_meter_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 68
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// Write one word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one word, registered; old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/psrba_alloc.sv
module psrba_alloc #(
	parameter int BLOCK_ID_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  psrba_pkg::alloc_req_t    req,
	output logic [BLOCK_ID_BITS-1:0] id,
	output logic                     ovf
);

	logic [BLOCK_ID_BITS:0] cnt_q;
	logic                   ovf_q;
	logic [BLOCK_ID_BITS:0] base_cnt;
	logic                   base_ovf;
	logic                   exhausted;
	logic [BLOCK_ID_BITS:0] nxt_cnt;
	logic                   nxt_ovf;

	// Pick the next id; saturate at the id space and flag overflow
	always_comb begin
		base_cnt  = req.clear ? '0 : cnt_q;
		base_ovf  = req.clear ? 1'b0 : ovf_q;
		exhausted = base_cnt[BLOCK_ID_BITS];
		id        = exhausted ? '1 : base_cnt[BLOCK_ID_BITS-1:0];
		nxt_cnt   = (req.take && !exhausted) ? base_cnt + (BLOCK_ID_BITS+1)'(1) : base_cnt;
		nxt_ovf   = base_ovf || (req.take && exhausted);
	end

	assign ovf = nxt_ovf;

	// Advance the counter when a row commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (req.fire) begin
			cnt_q <= nxt_cnt;
			ovf_q <= nxt_ovf;
		end
	end

endmodule

### dv/per_shard_row_block_assigner_test.sv
module per_shard_row_block_assigner_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SHARD_W = psrba_pkg::SHARD_W;
	localparam int ROW_SIZE_W = psrba_pkg::ROW_SIZE_W;
	localparam int ROW_W = psrba_pkg::ROW_W;
	localparam int BYTE_W = psrba_pkg::BYTE_W;
	localparam int CFG_IDX_W = psrba_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = psrba_pkg::CFG_DATA_W;

	localparam int SHARDS = 16;
	localparam int ID_BITS = 16;
	localparam logic [ID_BITS:0] ID_SPACE = {1'b1, {ID_BITS{1'b0}}};
	localparam logic [ID_BITS:0] COUNT_SATURATED = {1'b1, {(ID_BITS-1){1'b0}}, 1'b1};
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam logic [ROW_W-1:0] ROW_LIMIT_MAX = '1;
	localparam logic [BYTE_W-1:0] BYTE_LIMIT_MAX = '1;
	localparam logic [ROW_SIZE_W-1:0] ROW_SIZE_MAX = '1;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic               opened;
		logic               ovf;
	} block_word_t;

	// One line of the directed table: either a register write or a row
	typedef struct {
		bit                     is_reg;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		bit                     first;
		logic [SHARD_W-1:0]     sh;
		logic [ROW_SIZE_W-1:0]  nbytes;
		bit                     known;
		block_word_t            want;
	} plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic first_row = 1'b0;
	logic [SHARD_W-1:0] shard = '0;
	logic [ROW_SIZE_W-1:0] row_size = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ID_BITS-1:0] block_id;
	logic opened_block;
	logic overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the block's limits and shard meters
	logic [ROW_W-1:0] row_lim = psrba_pkg::ROW_LIMIT_RST;
	logic [BYTE_W-1:0] byte_lim = psrba_pkg::BYTE_LIMIT_RST;
	bit meter_live [SHARDS];
	logic [ROW_W-1:0] meter_rows [SHARDS];
	logic [BYTE_W-1:0] meter_bytes [SHARDS];
	logic [ID_BITS-1:0] meter_block [SHARDS];
	logic [ID_BITS:0] ids_issued = '0;

	block_word_t expected_blocks [$];
	plan_t directed_plan [$];
	int mismatches = 0;
	int words_seen = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	int stall_left = 0;
	logic [SHARD_W-1:0] hot_shard = '0;

	per_shard_row_block_assigner #(
		.SHARDS(SHARDS),
		.BLOCK_ID_BITS(ID_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.first_row(first_row),
		.shard(shard),
		.row_size(row_size),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.block_id(block_id),
		.opened_block(opened_block),
		.overflow(overflow),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Place one row into its shard's block, next-fit, and return the word it yields
	function automatic block_word_t assign_row(bit first, logic [SHARD_W-1:0] sh,
			logic [ROW_SIZE_W-1:0] nbytes);
		block_word_t w;
		int s;
		logic [BYTE_W:0] sum;
		if (first) begin
			for (int i = 0; i < SHARDS; i++)
				meter_live[i] = 1'b0;
			ids_issued = '0;
		end
		s = int'(sh) % SHARDS;
		w.opened = 1'b0;
		sum = {1'b0, meter_bytes[s]} + (BYTE_W + 1)'(nbytes);
		if (!meter_live[s] || meter_rows[s] >= row_lim || sum > {1'b0, byte_lim}) begin
			if (ids_issued < ID_SPACE) begin
				meter_block[s] = ids_issued[ID_BITS-1:0];
				ids_issued = ids_issued + (ID_BITS + 1)'(1);
			end else begin
				meter_block[s] = '1;
				ids_issued = COUNT_SATURATED;
			end
			meter_live[s] = 1'b1;
			meter_rows[s] = '0;
			meter_bytes[s] = '0;
			w.opened = 1'b1;
		end
		meter_rows[s] = meter_rows[s] + ROW_W'(1);
		meter_bytes[s] = meter_bytes[s] + BYTE_W'(nbytes);
		w.id = meter_block[s];
		w.ovf = (ids_issued == COUNT_SATURATED);
		return w;
	endfunction

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ROW_SIZE_W-1:0] rand_bytes();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return ROW_SIZE_MAX;
		if (r < 55)
			return ROW_SIZE_W'($urandom_range(0, 512));
		if (r < 80)
			return ROW_SIZE_W'($urandom_range(0, 24'h3FFFF));
		return ROW_SIZE_W'($urandom);
	endfunction

	function automatic logic [SHARD_W-1:0] rand_shard();
		if ($urandom_range(0, 99) < 30)
			return hot_shard;
		return SHARD_W'($urandom_range(0, SHARDS - 1));
	endfunction

	function automatic void plan_row(bit first, logic [SHARD_W-1:0] sh,
			logic [ROW_SIZE_W-1:0] nbytes);
		plan_t p;
		p = '{default: '0};
		p.first = first;
		p.sh = sh;
		p.nbytes = nbytes;
		directed_plan.insert(directed_plan.size(), p);
	endfunction

	function automatic void plan_known(bit first, logic [SHARD_W-1:0] sh,
			logic [ROW_SIZE_W-1:0] nbytes, int id, bit opened, bit ovf);
		plan_t p;
		p = '{default: '0};
		p.first = first;
		p.sh = sh;
		p.nbytes = nbytes;
		p.known = 1'b1;
		p.want = '{id: ID_BITS'(id), opened: opened, ovf: ovf};
		directed_plan.insert(directed_plan.size(), p);
	endfunction

	function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		plan_t p;
		p = '{default: '0};
		p.is_reg = 1'b1;
		p.idx = idx;
		p.data = data;
		directed_plan.insert(directed_plan.size(), p);
	endfunction

	// Offer one row after a random gap, hold it until taken, then queue its word
	task automatic send_row(bit first, logic [SHARD_W-1:0] sh, logic [ROW_SIZE_W-1:0] nbytes,
			bit known = 1'b0, block_word_t want = '0);
		int gap;
		block_word_t w;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_row <= first;
		shard <= sh;
		row_size <= nbytes;
		do
			@(posedge clk);
		while (!in_ready);
		w = assign_row(first, sh, nbytes);
		expected_blocks.insert(expected_blocks.size(), known ? want : w);
	endtask

	// Write one register, then hold the channel idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == psrba_pkg::REG_ROW_LIMIT)
			row_lim = data[ROW_W-1:0];
		else if (idx == psrba_pkg::REG_BYTE_LIMIT)
			byte_lim = data;
		@(posedge clk);
	endtask

	// Drop valid and drain every outstanding word, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: stall at random, steady ready while quiet
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < 30)
				stall_left <= pick_gap();
		end
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		block_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_blocks.size() == 0) begin
				mismatches++;
				$display("%0t: expected no word, got id %0d opened %0b overflow %0b",
					$realtime, block_id, opened_block, overflow);
			end else begin
				want = expected_blocks.pop_front();
				if (block_id !== want.id || opened_block !== want.opened ||
						overflow !== want.ovf) begin
					mismatches++;
					$display({"%0t: word %0d expected id %0d opened %0b overflow %0b,",
						" got id %0d opened %0b overflow %0b"},
						$realtime, words_seen, want.id, want.opened, want.ovf,
						block_id, opened_block, overflow);
				end
			end
			words_seen++;
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("[per_shard_row_block_assigner] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		int k;
		int pick;
		logic [ROW_W-1:0] rl;
		logic [BYTE_W-1:0] bl;
		plan_t p;

		// Directed table: known words right after reset and at the last restart, the rest predicted
		plan_known(1'b0, 4'd0, 24'd0, 0, 1'b1, 1'b0);
		plan_known(1'b0, 4'd15, ROW_SIZE_MAX, 1, 1'b1, 1'b0);
		plan_known(1'b0, 4'd0, 24'd100, 0, 1'b0, 1'b0);
		plan_known(1'b0, 4'd15, ROW_SIZE_MAX, 1, 1'b0, 1'b0);
		plan_known(1'b1, 4'd5, 24'd7, 0, 1'b1, 1'b0);
		plan_known(1'b0, 4'd0, 24'd1, 1, 1'b1, 1'b0);
		plan_row(1'b0, 4'd15, 24'd0);
		plan_reg(psrba_pkg::REG_ROW_LIMIT, 32'd2);
		plan_row(1'b0, 4'd5, 24'd1);
		plan_row(1'b0, 4'd5, 24'd1);
		plan_reg(psrba_pkg::REG_BYTE_LIMIT, 32'd10);
		plan_reg(psrba_pkg::REG_ROW_LIMIT, CFG_DATA_W'(ROW_LIMIT_MAX));
		plan_row(1'b0, 4'd3, 24'd11);
		plan_row(1'b0, 4'd3, 24'd0);
		plan_row(1'b0, 4'd3, 24'd10);
		plan_row(1'b0, 4'd3, 24'd1);
		plan_reg(psrba_pkg::REG_ROW_LIMIT, 32'd0);
		plan_row(1'b0, 4'd7, 24'd0);
		plan_row(1'b0, 4'd7, 24'd0);
		plan_reg(psrba_pkg::REG_ROW_LIMIT, 32'd65536);
		plan_reg(psrba_pkg::REG_BYTE_LIMIT, 32'd0);
		plan_row(1'b0, 4'd2, 24'd0);
		plan_row(1'b0, 4'd2, 24'd0);
		plan_row(1'b0, 4'd2, 24'd1);
		plan_reg(REG_SPARE_2, 32'hFFFF_FFFF);
		plan_reg(REG_SPARE_3, 32'h0000_0001);
		plan_reg(psrba_pkg::REG_BYTE_LIMIT, BYTE_LIMIT_MAX);
		plan_known(1'b1, 4'd9, ROW_SIZE_MAX, 0, 1'b1, 1'b0);
		plan_row(1'b0, 4'd9, ROW_SIZE_MAX);
		plan_row(1'b0, 4'd9, 24'hAAAAAA);
		plan_row(1'b0, 4'd9, 24'h555555);

		// Hold reset, then release at an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			p = directed_plan[i];
			if (p.is_reg) begin
				wait_idle();
				write_reg(p.idx, p.data);
			end else begin
				send_row(p.first, p.sh, p.nbytes, p.known, p.want);
			end
		end

		// Small rows over three shards under the widest row limit
		wait_idle();
		write_reg(psrba_pkg::REG_ROW_LIMIT, CFG_DATA_W'(ROW_LIMIT_MAX));
		for (k = 0; k < 24; k++)
			send_row(1'b0, SHARD_W'(k % 3), ROW_SIZE_W'(k));

		// Random phases, each under its own pair of limits
		for (phase = 0; phase < 6; phase++) begin
			wait_idle();
			pick = $urandom_range(0, 5);
			case (pick)
				0: rl = 20'd1;
				1: rl = ROW_W'($urandom_range(2, 8));
				2: rl = ROW_LIMIT_MAX;
				3: rl = '0;
				default: rl = ROW_W'($urandom);
			endcase
			pick = $urandom_range(0, 5);
			case (pick)
				0: bl = BYTE_W'($urandom_range(0, 1024));
				1: bl = BYTE_W'($urandom_range(24'h40000, 26'h3FFFFFF));
				2: bl = BYTE_LIMIT_MAX;
				3: bl = 32'd1;
				default: bl = $urandom;
			endcase
			write_reg(psrba_pkg::REG_ROW_LIMIT, CFG_DATA_W'(rl));
			write_reg(psrba_pkg::REG_BYTE_LIMIT, bl);
			if ($urandom_range(0, 1))
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
			quiet = (phase == 2);
			for (k = 0; k < 310; k++) begin
				if (k % 64 == 0) begin
					hot_shard = SHARD_W'($urandom_range(0, SHARDS - 1));
					if (phase != 2)
						quiet = ($urandom_range(0, 3) == 0);
				end
				send_row((phase == 0 && k == 0) || $urandom_range(0, 99) < 2,
					rand_shard(), rand_bytes());
			end
		end
		quiet = 1'b0;

		// Drain, settle, report
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_blocks.size() == 0)
			$display("[per_shard_row_block_assigner] OK");
		else
			$display("[per_shard_row_block_assigner] ERROR");
		$finish;
	end

endmodule
